// ----- rtl/rsti_pkg.sv -----
// Shared types, constants and helpers for the radix string-to-integer converter.
package rsti_pkg;

    // Datapath sizes
    localparam int VALUE_BITS   = 64;
    localparam int OFFSET_BITS  = 16;
    localparam int OUT_VALUE_W  = 64;
    localparam int OUT_OFFSET_W = 16;
    localparam int CHR_BITS     = 8;
    localparam int BASE_BITS    = 6;
    localparam int STATUS_BITS  = 2;

    // Token queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    // Configuration port
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam logic [PADDR_BITS-3:0] REG_RADIX = '0;
    localparam logic [BASE_BITS-1:0]  RADIX_RESET = BASE_BITS'(10);

    // Character codes and bases
    localparam logic [CHR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHR_BITS-1:0] CH_0     = 8'h30;
    localparam logic [CHR_BITS-1:0] CH_9     = 8'h39;
    localparam logic [CHR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHR_BITS-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHR_BITS-1:0] CH_LX    = 8'h78;

    localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
    localparam logic [BASE_BITS-1:0] BASE_ONE  = BASE_BITS'(1);
    localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
    localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);
    localparam logic [BASE_BITS-1:0] BASE_MAX  = BASE_BITS'(36);
    localparam logic [BASE_BITS-1:0] DIGIT_NONE = '1;

    // Parse phase
    typedef enum logic [2:0] {
        PH_WS,
        PH_AFTER_SIGN,
        PH_ZERO,
        PH_NEED_DIGIT,
        PH_DIGITS,
        PH_ERROR
    } phase_t;

    // Result status
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_BAD_RADIX,
        ST_BAD_CHAR,
        ST_NO_DIGITS
    } status_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic                   term;
        logic                   ws;
        logic                   minus;
        logic                   plus;
        logic                   zero;
        logic                   hex_x;
        logic [BASE_BITS-1:0]   digit;
        logic [OFFSET_BITS-1:0] pos;
    } token_t;

    // Digit value of a byte, DIGIT_NONE when not alphanumeric
    function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHR_BITS-1:0] c);
        logic [BASE_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9)
            d = BASE_BITS'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LZ)
            d = BASE_BITS'(c - CH_LA) + BASE_DEC;
        else if (c >= CH_UA && c <= CH_UZ)
            d = BASE_BITS'(c - CH_UA) + BASE_DEC;
        return d;
    endfunction

    // Low bits of the position, zero-extended when the counter is narrow
    function automatic logic [OUT_OFFSET_W-1:0] offset_out(input logic [OFFSET_BITS-1:0] p);
        logic [OFFSET_BITS+OUT_OFFSET_W-1:0] ext;
        ext = {{OUT_OFFSET_W{1'b0}}, p};
        return ext[OUT_OFFSET_W-1:0];
    endfunction

    // Sign-extend the wrapped value to the result width
    function automatic logic [OUT_VALUE_W-1:0] value_out(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+OUT_VALUE_W-1:0] ext;
        ext = {{OUT_VALUE_W{v[VALUE_BITS-1]}}, v};
        return ext[OUT_VALUE_W-1:0];
    endfunction

endpackage

// ----- rtl/rsti_front.sv -----
// Front end: accepts string bytes, classifies them and tracks the byte position.
module rsti_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsti_pkg::CHR_BITS-1:0]  s_chr,
    input  logic                           q_full,
    output logic                           q_push,
    output rsti_pkg::token_t               q_token
);
    import rsti_pkg::*;

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Byte classification
    always_comb begin
        q_token.term  = (s_chr == CH_NUL);
        q_token.ws    = (s_chr >= CH_TAB && s_chr <= CH_CR) || (s_chr == CH_SPACE);
        q_token.minus = (s_chr == CH_MINUS);
        q_token.plus  = (s_chr == CH_PLUS);
        q_token.zero  = (s_chr == CH_0);
        q_token.hex_x = (s_chr == CH_LX) || (s_chr == CH_UX);
        q_token.digit = digit_of(s_chr);
        q_token.pos   = pos_reg;
    end

    // Position counter: saturates, restarts after the terminator
    always_comb begin
        pos_next = pos_reg;
        if (q_push) begin
            if (q_token.term)
                pos_next = '0;
            else if (pos_reg != {OFFSET_BITS{1'b1}})
                pos_next = pos_reg + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// ----- rtl/rsti_queue.sv -----
// Two-entry token queue between the front end and the parser.
module rsti_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rsti_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output rsti_pkg::token_t head
);
    import rsti_pkg::*;

    token_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QPTR_BITS:0]     count_reg;
    logic [QPTR_BITS:0]     count_next;

    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0
                                                                    : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0
                                                                    : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !pop)
            count_next = count_reg + (QPTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_BITS+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_token;
    end

endmodule

// ----- rtl/rsti_back.sv -----
// Parser back end: sign/prefix state machine, multiply-add accumulator, result register.
module rsti_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [rsti_pkg::BASE_BITS-1:0]     radix,
    input  logic                               q_not_empty,
    input  rsti_pkg::token_t                   q_head,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rsti_pkg::OUT_VALUE_W-1:0]  m_value,
    output logic [rsti_pkg::STATUS_BITS-1:0]   m_status,
    output logic [rsti_pkg::OUT_OFFSET_W-1:0]  m_end_offset
);
    import rsti_pkg::*;

    // String state
    phase_t                 phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [BASE_BITS-1:0]   base_reg, base_next;
    status_t                err_reg, err_next;
    logic [OFFSET_BITS-1:0] errpos_reg, errpos_next;

    // Result register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_VALUE_W-1:0]  m_value_reg, m_value_next;
    status_t                 m_status_reg, m_status_next;
    logic [OUT_OFFSET_W-1:0] m_end_offset_reg, m_end_offset_next;

    // State after radix sampling at the first byte
    logic                   first;
    logic                   radix_bad;
    phase_t                 phase_cur;
    logic [BASE_BITS-1:0]   base_cur;
    status_t                err_cur;
    logic [OFFSET_BITS-1:0] errpos_cur;

    logic                   out_free;
    logic                   digit_take;
    logic [BASE_BITS-1:0]   digit_base;
    logic [VALUE_BITS-1:0]  mac;
    logic [VALUE_BITS-1:0]  signed_acc;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_not_empty && (!q_head.term || out_free);

    assign first     = (q_head.pos == '0);
    assign radix_bad = (radix == BASE_ONE) || (radix > BASE_MAX);

    always_comb begin
        phase_cur  = phase_reg;
        base_cur   = base_reg;
        err_cur    = err_reg;
        errpos_cur = errpos_reg;
        if (first) begin
            base_cur = radix;
            if (radix_bad) begin
                phase_cur  = PH_ERROR;
                err_cur    = ST_BAD_RADIX;
                errpos_cur = '0;
            end
        end
    end

    // Next-state logic
    always_comb begin
        logic start;
        logic digit_en;
        start       = 1'b0;
        digit_en    = 1'b0;
        digit_base  = base_cur;
        digit_take  = 1'b0;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        err_next    = err_reg;
        errpos_next = errpos_reg;
        if (q_pop) begin
            if (q_head.term) begin
                phase_next  = PH_WS;
                neg_next    = 1'b0;
                base_next   = '0;
                err_next    = ST_OK;
                errpos_next = '0;
            end else begin
                phase_next  = phase_cur;
                base_next   = base_cur;
                err_next    = err_cur;
                errpos_next = errpos_cur;
                unique case (phase_cur)
                    PH_WS: begin
                        if (q_head.ws) begin
                            phase_next = PH_WS;
                        end else if (q_head.minus) begin
                            neg_next   = 1'b1;
                            phase_next = PH_AFTER_SIGN;
                        end else if (q_head.plus) begin
                            phase_next = PH_AFTER_SIGN;
                        end else begin
                            start = 1'b1;
                        end
                    end
                    PH_AFTER_SIGN: begin
                        start = 1'b1;
                    end
                    PH_ZERO: begin
                        if (q_head.hex_x) begin
                            base_next  = BASE_HEX;
                            phase_next = PH_NEED_DIGIT;
                        end else begin
                            digit_en   = 1'b1;
                            digit_base = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
                        end
                    end
                    PH_NEED_DIGIT, PH_DIGITS: begin
                        digit_en = 1'b1;
                    end
                    default: begin
                        phase_next = phase_cur;
                    end
                endcase
                // Leading zero in auto or hex mode may open a prefix
                if (start) begin
                    if (q_head.zero && (base_cur == BASE_AUTO || base_cur == BASE_HEX)) begin
                        phase_next = PH_ZERO;
                    end else begin
                        digit_en   = 1'b1;
                        digit_base = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
                    end
                end
                if (digit_en) begin
                    if (q_head.digit >= digit_base) begin
                        phase_next  = PH_ERROR;
                        err_next    = ST_BAD_CHAR;
                        errpos_next = q_head.pos;
                    end else begin
                        digit_take = 1'b1;
                        phase_next = PH_DIGITS;
                        base_next  = digit_base;
                    end
                end
            end
        end
    end

    // Accumulator and result datapath
    assign mac        = acc_reg * VALUE_BITS'(digit_base) + VALUE_BITS'(q_head.digit);
    assign signed_acc = neg_reg ? (VALUE_BITS'(0) - acc_reg) : acc_reg;

    always_comb begin
        acc_next          = acc_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_value_next      = m_value_reg;
        m_status_next     = m_status_reg;
        m_end_offset_next = m_end_offset_reg;
        if (q_pop) begin
            if (q_head.term) begin
                acc_next     = '0;
                m_valid_next = 1'b1;
                if (phase_cur == PH_ERROR) begin
                    m_value_next      = '0;
                    m_status_next     = err_cur;
                    m_end_offset_next = offset_out(errpos_cur);
                end else if (phase_cur == PH_ZERO || phase_cur == PH_DIGITS) begin
                    m_value_next      = value_out(signed_acc);
                    m_status_next     = ST_OK;
                    m_end_offset_next = offset_out(q_head.pos);
                end else begin
                    m_value_next      = '0;
                    m_status_next     = ST_NO_DIGITS;
                    m_end_offset_next = offset_out(q_head.pos);
                end
            end else if (digit_take) begin
                acc_next = mac;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WS;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            base_reg    <= '0;
            err_reg     <= ST_OK;
            errpos_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            base_reg    <= base_next;
            err_reg     <= err_next;
            errpos_reg  <= errpos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg      <= m_value_next;
        m_status_reg     <= m_status_next;
        m_end_offset_reg <= m_end_offset_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_end_offset = m_end_offset_reg;

endmodule

// ----- rtl/radix_string_to_integer.sv -----
// Top level: streaming string-to-integer converter with radix register.
// Throughput: one string byte per cycle. A terminator waits while the output register holds
// an untaken result; input stalls once the two-entry queue fills. Multiply-add sets clock path.
// Result path: the terminating zero byte is written into the queue, and the parser moves its
// result into the output register when that register is free to take it.
// Reset (aresetn low, synchronous): radix returns to 10, string state, queue and output valid cleared.
module radix_string_to_integer (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // Configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [rsti_pkg::PADDR_BITS-1:0]          paddr,
    input  logic [rsti_pkg::PDATA_BITS-1:0]          pwdata,
    output logic [rsti_pkg::PDATA_BITS-1:0]          prdata,
    output logic                                     pready,
    // Input bytes
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [rsti_pkg::CHR_BITS-1:0]            s_chr,
    // Results
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [rsti_pkg::OUT_VALUE_W-1:0]  m_value,
    output logic [rsti_pkg::STATUS_BITS-1:0]         m_status,
    output logic [rsti_pkg::OUT_OFFSET_W-1:0]        m_end_offset
);
    import rsti_pkg::*;

    logic [BASE_BITS-1:0] radix_reg;
    logic [BASE_BITS-1:0] radix_next;
    logic                 radix_sel;

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_not_empty;
    token_t q_in_token;
    token_t q_head;

    // Register file: radix only
    assign pready    = 1'b1;
    assign radix_sel = (paddr[PADDR_BITS-1:2] == REG_RADIX);
    assign prdata    = radix_sel ? PDATA_BITS'(radix_reg) : '0;

    always_comb begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && pready && radix_sel)
            radix_next = pwdata[BASE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            radix_reg <= RADIX_RESET;
        else
            radix_reg <= radix_next;
    end

    rsti_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_chr   (s_chr),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_token (q_in_token)
    );

    rsti_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (q_in_token),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    rsti_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .radix        (radix_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status),
        .m_end_offset (m_end_offset)
    );

endmodule

// ----- verif/tb_radix_string_to_integer.sv -----
// Testbench for radix_string_to_integer: directed and random strings scored against a parser model.
`timescale 1ns / 100ps

module tb_radix_string_to_integer;
    import rsti_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int LONG_PAD       = 150;
    localparam logic [PADDR_BITS-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

    typedef struct {
        logic [OUT_VALUE_W-1:0]  value;
        status_t                 status;
        logic [OUT_OFFSET_W-1:0] offset;
    } conv_result_t;

    // DUT connections
    logic                           aclk;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [PADDR_BITS-1:0]          paddr;
    logic [PDATA_BITS-1:0]          pwdata;
    logic [PDATA_BITS-1:0]          prdata;
    logic                           pready;
    logic                           s_valid;
    logic                           s_ready;
    logic [CHR_BITS-1:0]            s_chr;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [OUT_VALUE_W-1:0]  m_value;
    logic [STATUS_BITS-1:0]         m_status;
    logic [OUT_OFFSET_W-1:0]        m_end_offset;

    // Parser model state
    logic [BASE_BITS-1:0]   radix_cfg;
    phase_t                 ps_phase;
    logic                   ps_neg;
    logic [VALUE_BITS-1:0]  ps_acc;
    logic [BASE_BITS-1:0]   ps_base;
    logic [OFFSET_BITS-1:0] ps_pos;
    status_t                ps_err;
    logic [OFFSET_BITS-1:0] ps_err_pos;

    conv_result_t pending_results[$];

    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  stuck_cycles = 0;
    int  stall_left   = 0;
    bit  src_idle_on  = 1'b1;
    bit  snk_idle_on  = 1'b1;

    radix_string_to_integer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chr        (s_chr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status),
        .m_end_offset (m_end_offset)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        ps_phase   = PH_WS;
        ps_neg     = 1'b0;
        ps_acc     = '0;
        ps_base    = BASE_AUTO;
        ps_pos     = '0;
        ps_err     = ST_OK;
        ps_err_pos = '0;
    endfunction

    function automatic void flag_error(status_t code, logic [OFFSET_BITS-1:0] at);
        ps_err     = code;
        ps_err_pos = at;
        ps_phase   = PH_ERROR;
    endfunction

    // Digit value 0..35, 127 for anything that is not alphanumeric
    function automatic logic [6:0] char_digit(logic [CHR_BITS-1:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 7'(c - CH_0);
        if (c >= CH_LA && c <= CH_LZ)
            return 7'(c - CH_LA) + 7'd10;
        if (c >= CH_UA && c <= CH_UZ)
            return 7'(c - CH_UA) + 7'd10;
        return 7'h7F;
    endfunction

    function automatic void take_digit(logic [CHR_BITS-1:0] c, logic [OFFSET_BITS-1:0] at);
        logic [6:0] d;
        d = char_digit(c);
        if (d >= 7'(ps_base)) begin
            flag_error(ST_BAD_CHAR, at);
        end else begin
            ps_acc   = ps_acc * VALUE_BITS'(ps_base) + VALUE_BITS'(d);
            ps_phase = PH_DIGITS;
        end
    endfunction

    // First character of the number proper; a zero may open a prefix
    function automatic void start_number(logic [CHR_BITS-1:0] c, logic [OFFSET_BITS-1:0] at);
        if (c == CH_0 && (ps_base == BASE_AUTO || ps_base == BASE_HEX)) begin
            ps_acc   = '0;
            ps_phase = PH_ZERO;
        end else begin
            if (ps_base == BASE_AUTO)
                ps_base = BASE_DEC;
            take_digit(c, at);
        end
    endfunction

    // Advance the model by one accepted byte; a terminator queues a result
    function automatic void parse_byte(logic [CHR_BITS-1:0] c);
        logic [OFFSET_BITS-1:0] at;
        conv_result_t           r;
        at = ps_pos;

        // radix is latched at the first byte of each string
        if (ps_phase == PH_WS && at == '0) begin
            if (radix_cfg == BASE_ONE || radix_cfg > BASE_MAX)
                flag_error(ST_BAD_RADIX, '0);
            else
                ps_base = radix_cfg;
        end

        if (c == CH_NUL) begin
            r.value  = '0;
            r.status = ST_NO_DIGITS;
            r.offset = OUT_OFFSET_W'(at);
            if (ps_phase == PH_ERROR) begin
                r.status = ps_err;
                r.offset = OUT_OFFSET_W'(ps_err_pos);
            end else if (ps_phase == PH_ZERO || ps_phase == PH_DIGITS) begin
                r.value  = ps_neg ? (OUT_VALUE_W'(0) - ps_acc) : ps_acc;
                r.status = ST_OK;
            end
            pending_results.push_back(r);
            clear_parse();
            return;
        end

        case (ps_phase)
            PH_WS: begin
                if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
                    // leading whitespace is skipped
                end else if (c == CH_MINUS) begin
                    ps_neg   = 1'b1;
                    ps_phase = PH_AFTER_SIGN;
                end else if (c == CH_PLUS) begin
                    ps_phase = PH_AFTER_SIGN;
                end else begin
                    start_number(c, at);
                end
            end
            PH_AFTER_SIGN: start_number(c, at);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    ps_base  = BASE_HEX;
                    ps_phase = PH_NEED_DIGIT;
                end else begin
                    if (ps_base == BASE_AUTO)
                        ps_base = BASE_OCT;
                    ps_phase = PH_DIGITS;
                    take_digit(c, at);
                end
            end
            PH_NEED_DIGIT, PH_DIGITS: take_digit(c, at);
            default: ;
        endcase

        if (ps_pos != '1)
            ps_pos++;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle_len(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [CHR_BITS-1:0] c);
        int gap;
        gap = pick_idle_len(src_idle_on);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_chr   <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
        send_byte(CH_NUL);
    endtask

    // Let every outstanding result come back, then give the pipe time to empty
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the radix register, then read it back
    task automatic apply_radix(input logic [BASE_BITS-1:0] val);
        logic [PDATA_BITS-1:0] wdata;
        wait_for_results();
        wdata = $urandom;
        wdata[BASE_BITS-1:0] = val;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIX_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        radix_cfg = val;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[BASE_BITS-1:0] !== val)
            report_mismatch($sformatf("radix readback %0d, wrote %0d",
                                      prdata[BASE_BITS-1:0], val));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Result-side backpressure
    always @(negedge aclk) begin
        int len;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            len = pick_idle_len(snk_idle_on);
            if (len > 0) begin
                stall_left = len - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result scoreboard
    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d status=%0d offset=%0d",
                                          m_value, m_status, m_end_offset));
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d", m_value,
                                              $signed(want.value)));
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_end_offset !== want.offset)
                    report_mismatch($sformatf("end_offset %0d, want %0d", m_end_offset,
                                              want.offset));
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Radix 10 from reset: whitespace, signs, empty, bad characters, wrap-around
    task automatic test_decimal();
        send_text("");
        send_text("   ");
        send_text("-");
        send_text("+7");
        for (logic [CHR_BITS-1:0] w = CH_TAB; w <= CH_CR; w++)
            send_byte(w);
        send_byte(CH_SPACE);
        send_text("-123");
        send_text("12a");
        send_text("- 5");
        send_text("+-5");
        send_text("0");
        send_text("18446744073709551615");
        send_text("99999999999999999999");
        send_text("-9223372036854775808");
    endtask

    // Auto-detect: prefixes, lone zero, octal digits
    task automatic test_auto_base();
        apply_radix(BASE_AUTO);
        send_text("0");
        send_text("-0");
        send_text("0x1F");
        send_text("0XaB");
        send_text("0x");
        send_text("017");
        send_text("09");
        send_text("0xg");
        send_text("42");
        send_text("-0x10");
        send_text("+");
    endtask

    // Hex: optional prefix, full width, wrap to zero
    task automatic test_hex_base();
        apply_radix(BASE_HEX);
        send_text("0");
        send_text("0x");
        send_text("0xFFFFFFFFFFFFFFFF");
        send_text("-ff");
        send_text("FfFf");
        send_text("0X10");
        send_text("zz");
        send_text("10000000000000000");
        send_text("0g");
    endtask

    // Smallest and largest valid bases, and invalid ones
    task automatic test_odd_radices();
        apply_radix(BASE_BITS'(2));
        send_text("101");
        send_text("1012");
        apply_radix(BASE_MAX);
        send_text("Zz09");
        send_text("-zZ");
        apply_radix(BASE_OCT);
        send_text("777");
        send_text("8");
        apply_radix(BASE_ONE);
        send_text("5");
        send_text("");
        apply_radix(BASE_BITS'(37));
        send_text("abc");
        apply_radix('1);
        send_text("1");
    endtask

    // Long runs of whitespace: offsets well past the first bytes, back to back
    task automatic test_long_string();
        apply_radix(BASE_DEC);
        src_idle_on = 1'b0;
        for (int i = 0; i < LONG_PAD; i++)
            send_byte(CH_SPACE);
        send_text("12");
        for (int i = 0; i < LONG_PAD; i++)
            send_byte(CH_SPACE);
        send_text("!");
        src_idle_on = 1'b1;
    endtask

    // One random string: mostly well formed, some corrupted, some pure noise
    task automatic send_random_string();
        logic [CHR_BITS-1:0] bytes[$];
        int kind, base, ndig, d, lo, r;
        bit lead_nonzero;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(0, 8)) bytes.push_back(CHR_BITS'($urandom_range(1, 255)));
        end else begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
                r = $urandom_range(0, 5);
                bytes.push_back(r < 5 ? CH_TAB + CHR_BITS'(r) : CH_SPACE);
            end
            r = $urandom_range(0, 3);
            if (r == 0)
                bytes.push_back(CH_MINUS);
            else if (r == 1)
                bytes.push_back(CH_PLUS);

            base = int'(radix_cfg);
            lead_nonzero = 1'b0;
            if (base == int'(BASE_AUTO)) begin
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    bytes.push_back(CH_0);
                    bytes.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                    base = int'(BASE_HEX);
                end else if (r == 1) begin
                    bytes.push_back(CH_0);
                    base = int'(BASE_OCT);
                end else begin
                    base = int'(BASE_DEC);
                    lead_nonzero = 1'b1;
                end
            end else if (base == int'(BASE_HEX) && $urandom_range(0, 1)) begin
                bytes.push_back(CH_0);
                bytes.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end else if (base == int'(BASE_ONE) || base > int'(BASE_MAX)) begin
                base = int'(BASE_DEC);
            end

            if ($urandom_range(0, 19) == 0)
                ndig = 0;
            else if ($urandom_range(0, 9) == 0)
                ndig = $urandom_range(15, 25);
            else
                ndig = $urandom_range(1, 8);
            for (int i = 0; i < ndig; i++) begin
                lo = (i == 0 && lead_nonzero) ? 1 : 0;
                d = $urandom_range(lo, base - 1);
                bytes.push_back(d < 10 ? CH_0 + CHR_BITS'(d) :
                                (($urandom_range(0, 1) != 0) ? CH_LA : CH_UA) +
                                CHR_BITS'(d - 10));
            end

            if (kind < 25 && bytes.size() != 0)
                bytes[$urandom_range(0, bytes.size() - 1)] = CHR_BITS'($urandom_range(1, 255));
        end
        foreach (bytes[i])
            send_byte(bytes[i]);
        send_byte(CH_NUL);
    endtask

    function automatic logic [BASE_BITS-1:0] pick_radix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return BASE_AUTO;
        if (r < 40) return BASE_HEX;
        if (r < 55) return BASE_DEC;
        if (r < 65) return BASE_BITS'(2);
        if (r < 72) return BASE_MAX;
        if (r < 77) return BASE_OCT;
        if (r < 90) return BASE_BITS'($urandom_range(2, 36));
        if (r < 95) return BASE_ONE;
        return BASE_BITS'($urandom_range(37, 63));
    endfunction

    // Random phases: new radix and idling mix every few strings
    task automatic test_random();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            apply_radix(pick_radix());
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(8, 15)) send_random_string();
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        s_valid = 1'b0;
        s_chr   = '0;
        m_ready = 1'b0;
        radix_cfg = RADIX_RESET;
        clear_parse();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_decimal();
        test_auto_base();
        test_hex_base();
        test_odd_radices();
        test_long_string();
        test_random();
        wait_for_results();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
